// ===== hdl/modbus_rtu_response_checker_assert.svh =====
// Assertion macros for the Modbus RTU response checker.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MRC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mrc_pkg.sv =====
// Package for the Modbus RTU response checker: types, codes and CRC function.
package mrc_pkg;

    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    localparam logic [1:0] KIND_READ      = 2'd0;
    localparam logic [1:0] KIND_WRITE_ONE = 2'd1;
    localparam logic [1:0] KIND_WRITE_MUL = 2'd2;

    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MUL   = 8'h10;
    localparam logic [7:0] FC_EXCEPT_MASK = 8'h80;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CRC_ERR = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic OUT_WORD   = 1'b0;
    localparam logic OUT_STATUS = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int          MIN_FRAME = 5;

    localparam int HF_SLAVE  = 0;
    localparam int HF_EXCEPT = 1;
    localparam int HF_FUNC   = 2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_first;
        logic       frame_last;
        logic [7:0] req_slave;
        logic [1:0] req_kind;
        logic [6:0] req_quantity;
    } mrc_in_t;

    typedef struct packed {
        logic        out_kind;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        logic [1:0]  frame_status;
        logic        is_last;
    } mrc_out_t;

    // Modbus CRC-16, one byte, reflected
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/modbus_rtu_response_checker.sv =====
// Modbus RTU response checker: byte-wise CRC, header checks, word extraction.
// Results of a word are written into the output queue when its byte is accepted and leave on m_data in order.
// Throughput: one byte per cycle while s_ready is high; a byte may yield two results
// (word + status), which drain one per cycle while m_ready is high, through a four-entry output queue.
// s_ready is low while fewer than two queue entries are free.
// Reset (aresetn low, synchronous) clears frame state and empties the queue.
`include "modbus_rtu_response_checker_assert.svh"

module modbus_rtu_response_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrc_pkg::mrc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mrc_pkg::mrc_out_t m_data
);
    import mrc_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // frame state
    logic [15:0]      crc_reg, crc_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [15:0]      tail_reg, tail_next;
    logic [15:0]      crc_dly_reg, crc_dly_next;
    logic [7:0]       hold_reg, hold_next;
    logic [2:0]       hdr_flags_reg, hdr_flags_next;
    logic [6:0]       word_cnt_reg, word_cnt_next;

    // output queue
    mrc_out_t          fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0] fifo_cnt_reg;

    logic s_acc, pop;
    logic push_word, push_stat;
    mrc_out_t word_res, stat_res;

    // working values
    logic [15:0]      cur_crc, cur_tail, cur_dly;
    logic [CNT_W-1:0] cur_cnt;
    logic [7:0]       cur_hold, d;
    logic [2:0]       cur_flags;
    logic [6:0]       cur_wcnt;
    logic [15:0]      upd_crc, upd_tail, upd_dly;
    logic [CNT_W-1:0] upd_cnt;
    logic [7:0]       upd_hold;
    logic [2:0]       upd_flags;
    logic [6:0]       upd_wcnt;
    logic             word_hit;
    logic             fc_bad;
    logic [15:0]      rx_crc;
    logic [1:0]       status;

    assign s_ready = fifo_cnt_reg <= FCNT_W'(FIFO_DEPTH - 2);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = fifo_cnt_reg != '0;
    assign pop     = m_valid && m_ready;
    assign m_data  = fifo_mem[rd_ptr_reg];

    always_comb begin
        if (s_data.frame_first) begin
            cur_crc   = CRC_INIT;
            cur_cnt   = '0;
            cur_tail  = '0;
            cur_dly   = CRC_INIT;
            cur_hold  = '0;
            cur_flags = '0;
            cur_wcnt  = '0;
        end else begin
            cur_crc   = crc_reg;
            cur_cnt   = byte_cnt_reg;
            cur_tail  = tail_reg;
            cur_dly   = crc_dly_reg;
            cur_hold  = hold_reg;
            cur_flags = hdr_flags_reg;
            cur_wcnt  = word_cnt_reg;
        end

        d = cur_tail[15:8];
        case (s_data.req_kind)
            KIND_READ:      fc_bad = d != FC_READ_HOLD;
            KIND_WRITE_ONE: fc_bad = d != FC_WRITE_ONE;
            KIND_WRITE_MUL: fc_bad = d != FC_WRITE_MUL;
            default:        fc_bad = 1'b0;
        endcase

        upd_crc   = cur_crc;
        upd_cnt   = cur_cnt;
        upd_tail  = cur_tail;
        upd_dly   = cur_dly;
        upd_hold  = cur_hold;
        upd_flags = cur_flags;
        upd_wcnt  = cur_wcnt;
        word_hit  = 1'b0;

        if (cur_cnt < CNT_W'(MAX_FRAME)) begin
            // tail high byte is now known to precede the CRC bytes
            if (cur_cnt >= CNT_W'(2)) begin
                upd_dly = crc_feed(cur_dly, d);
                if (cur_cnt == CNT_W'(2)) begin
                    if (d != s_data.req_slave) upd_flags[HF_SLAVE] = 1'b1;
                end else if (cur_cnt == CNT_W'(3)) begin
                    if ((d & FC_EXCEPT_MASK) != 8'h00) upd_flags[HF_EXCEPT] = 1'b1;
                    if (fc_bad) upd_flags[HF_FUNC] = 1'b1;
                end else if (cur_cnt >= CNT_W'(MIN_FRAME)) begin
                    if (cur_cnt[0]) begin
                        upd_hold = d;
                    end else if (s_data.req_kind == KIND_READ &&
                                 cur_wcnt < s_data.req_quantity) begin
                        word_hit = 1'b1;
                        upd_wcnt = cur_wcnt + 7'd1;
                    end
                end
            end
            upd_crc  = crc_feed(cur_crc, s_data.rx_byte);
            upd_tail = {cur_tail[7:0], s_data.rx_byte};
            upd_cnt  = cur_cnt + CNT_W'(1);
        end

        rx_crc = {upd_tail[7:0], upd_tail[15:8]};
        if (upd_cnt < CNT_W'(MIN_FRAME)) begin
            status = STAT_INVALID;
        end else if (upd_dly != rx_crc) begin
            status = STAT_CRC_ERR;
        end else if (upd_flags != 3'b000) begin
            status = STAT_INVALID;
        end else begin
            status = STAT_OK;
        end

        word_res.out_kind     = OUT_WORD;
        word_res.reg_index    = cur_wcnt;
        word_res.reg_value    = {cur_hold, d};
        word_res.frame_status = STAT_OK;
        word_res.is_last      = 1'b0;

        stat_res.out_kind     = OUT_STATUS;
        stat_res.reg_index    = '0;
        stat_res.reg_value    = '0;
        stat_res.frame_status = status;
        stat_res.is_last      = 1'b1;

        push_word = s_acc && word_hit;
        push_stat = s_acc && s_data.frame_last;

        if (s_data.frame_last) begin
            crc_next       = CRC_INIT;
            byte_cnt_next  = '0;
            tail_next      = '0;
            crc_dly_next   = CRC_INIT;
            hold_next      = '0;
            hdr_flags_next = '0;
            word_cnt_next  = '0;
        end else begin
            crc_next       = upd_crc;
            byte_cnt_next  = upd_cnt;
            tail_next      = upd_tail;
            crc_dly_next   = upd_dly;
            hold_next      = upd_hold;
            hdr_flags_next = upd_flags;
            word_cnt_next  = upd_wcnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            byte_cnt_reg  <= '0;
            tail_reg      <= '0;
            crc_dly_reg   <= CRC_INIT;
            hold_reg      <= '0;
            hdr_flags_reg <= '0;
            word_cnt_reg  <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fifo_cnt_reg  <= '0;
        end else begin
            if (s_acc) begin
                crc_reg       <= crc_next;
                byte_cnt_reg  <= byte_cnt_next;
                tail_reg      <= tail_next;
                crc_dly_reg   <= crc_dly_next;
                hold_reg      <= hold_next;
                hdr_flags_reg <= hdr_flags_next;
                word_cnt_reg  <= word_cnt_next;
            end
            wr_ptr_reg   <= wr_ptr_reg + PTR_W'(push_word) + PTR_W'(push_stat);
            rd_ptr_reg   <= rd_ptr_reg + PTR_W'(pop);
            fifo_cnt_reg <= fifo_cnt_reg + FCNT_W'(push_word) + FCNT_W'(push_stat)
                            - FCNT_W'(pop);
        end
    end

    // queue payload, no reset
    always_ff @(posedge aclk) begin
        if (push_word) begin
            fifo_mem[wr_ptr_reg] <= word_res;
        end
        if (push_stat) begin
            fifo_mem[wr_ptr_reg + PTR_W'(push_word)] <= stat_res;
        end
    end

    `MRC_ASSERT_SAME(a_fifo_bound, aclk, aresetn, 1'b1, fifo_cnt_reg <= FCNT_W'(FIFO_DEPTH), "output queue overflow")
    `MRC_ASSERT_SAME(a_cnt_bound, aclk, aresetn, 1'b1, byte_cnt_reg <= CNT_W'(MAX_FRAME), "byte count past buffer size")
    `MRC_ASSERT_NEXT(a_last_clears, aclk, aresetn, s_acc && s_data.frame_last, byte_cnt_reg == '0 && word_cnt_reg == '0 && m_valid, "frame state not cleared after last word")

endmodule
